/* design/spd_pkg.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// spd_pkg
// shared types and constants for the deadline shortest path block
// ----------------------------------------------------------------------------
package spd_pkg;
  localparam int MaxNodesDef = 64;
  localparam int MaxEdgesDef = 256;
  localparam int NodeW = 6;
  localparam int WeightW = 16;
  localparam int TimeW = 20;
  localparam int DistW = 21;
  localparam int CountW = 7;
  localparam logic [DistW-1:0] DistInf = '1;

  typedef enum logic [1:0] {
    CMD_CLEAR    = 2'd0,
    CMD_ADD_EDGE = 2'd1,
    CMD_DEADLINE = 2'd2,
    CMD_SOLVE    = 2'd3
  } cmd_t;

  typedef struct packed {
    logic [1:0]         command;
    logic [NodeW-1:0]   node_a;
    logic [NodeW-1:0]   node_b;
    logic [WeightW-1:0] edge_weight;
    logic [TimeW-1:0]   deadline;
  } in_item_t;

  typedef struct packed {
    logic [NodeW-1:0] node_index;
    logic [TimeW-1:0] reach_time;
    logic             reachable;
    logic             edges_dropped;
    logic             last;
  } out_item_t;
endpackage

/* design/spd_if.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// spd_in_if / spd_out_if
// valid/ready channels for command and result items
// ----------------------------------------------------------------------------
interface spd_in_if;
  logic valid;
  logic ready;
  spd_pkg::in_item_t data;
  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

interface spd_out_if;
  logic valid;
  logic ready;
  spd_pkg::out_item_t data;
  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

/* design/shortest_path_with_node_deadlines.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// shortest_path_with_node_deadlines
// dijkstra from node 0 with per-node deadlines, array scan over one unit
// ----------------------------------------------------------------------------
// Load commands (clear, add edge, set deadline) are taken while idle. A solve
// resets the distances, then runs up to n settled rounds, n = nodes in use:
// each round scans the nodes for the minimum (distance read, compare), picks
// and settles it, walks the stored edges (edge read, then distance and
// deadline read plus one relax compare for each direction) and closes the
// round. Results then go out one node at a time through a read state and an
// emit state, held while the receiver stalls. The input is not ready from the
// solve item until the last result is loaded. The edge, distance and deadline
// memories each have a single read port, so these steps run one after another.
module shortest_path_with_node_deadlines #(
  parameter int MAX_NODES = spd_pkg::MaxNodesDef,
  parameter int MAX_EDGES = spd_pkg::MaxEdgesDef
) (
  input  logic                       clk,
  input  logic                       rst,
  input  logic                       cfg_we,
  input  logic [spd_pkg::CountW-1:0] cfg_data,
  spd_in_if.sink                     in_ch,
  spd_out_if.source                  out_ch
);
  import spd_pkg::*;

  localparam int NW = $clog2(MAX_NODES);
  localparam int EW = (MAX_EDGES > 1) ? $clog2(MAX_EDGES) : 1;
  localparam int ECW = $clog2(MAX_EDGES + 1);
  localparam int EntW = 2 * NodeW + WeightW;

  typedef enum logic [3:0] {
    S_IDLE, S_INIT, S_SREAD, S_SCMP, S_PICK, S_EREAD, S_DREAD, S_RELAX, S_WAIT,
    S_EREQ, S_EMIT
  } state_t;

  state_t state;
  logic [CountW-1:0] node_count;
  logic [ECW-1:0] edge_count;
  logic overflow;
  logic [EntW-1:0] edge_mem [MAX_EDGES];
  logic [TimeW-1:0] dl_mem [MAX_NODES];
  logic [DistW-1:0] dist_mem [MAX_NODES];
  logic [MAX_NODES-1:0] dl_valid;
  logic [MAX_NODES-1:0] dist_ok;
  logic [MAX_NODES-1:0] settled;
  logic [TimeW-1:0] dl_q;
  logic dl_ok_q;
  logic [DistW-1:0] dist_q;
  logic dist_ok_q;
  logic [TimeW-1:0] dl_rd;
  logic [DistW-1:0] dist_rd;
  logic [NW-1:0] dist_ra;
  logic dist_we;
  logic [NW-1:0] dist_wa;
  logic [DistW-1:0] dist_wd;
  logic dl_we;
  logic relax_hit;
  logic [CountW-1:0] n_use;
  logic [CountW-1:0] idx;
  logic [ECW-1:0] eidx;
  logic [CountW-1:0] best;
  logic [DistW-1:0] best_d;
  logic [CountW-1:0] round;
  logic [EntW-1:0] ent;
  logic dir;
  logic [NodeW-1:0] ea, eb;
  logic [WeightW-1:0] ew;
  logic [NodeW-1:0] from, to;
  logic [DistW-1:0] cand;
  logic [NW-1:0] to_i, idx_i, best_i;
  logic in_range;

  assign in_ch.ready = (state == S_IDLE);
  assign ea = ent[EntW-1 -: NodeW];
  assign eb = ent[WeightW +: NodeW];
  assign ew = ent[WeightW-1:0];
  assign from = dir ? eb : ea;
  assign to = dir ? ea : eb;
  assign to_i = to[NW-1:0];
  assign idx_i = idx[NW-1:0];
  assign best_i = best[NW-1:0];
  assign cand = best_d + DistW'(ew);
  assign in_range = ({1'b0, ea} < n_use) && ({1'b0, eb} < n_use);

  assign dl_rd = dl_ok_q ? dl_q : '0;
  assign dist_rd = dist_ok_q ? dist_q : DistInf;
  assign dist_ra = (state == S_DREAD) ? to_i : idx_i;
  assign relax_hit = (state == S_RELAX) && in_range && ({1'b0, from} == best) &&
                     (cand < dist_rd) && (cand < {1'b0, dl_rd});
  assign dist_we = (state == S_INIT) || relax_hit;
  assign dist_wa = (state == S_INIT) ? '0 : to_i;
  assign dist_wd = (state == S_INIT) ? '0 : cand;
  assign dl_we = in_ch.valid && in_ch.ready && in_ch.data.command == CMD_DEADLINE &&
                 ({1'b0, in_ch.data.node_a} < CountW'(MAX_NODES));

  always_ff @(posedge clk) begin
    if (in_ch.valid && in_ch.ready && in_ch.data.command == CMD_ADD_EDGE &&
        edge_count < ECW'(MAX_EDGES))
      edge_mem[edge_count[EW-1:0]] <= {in_ch.data.node_a, in_ch.data.node_b,
                                       in_ch.data.edge_weight};
    if (state == S_EREAD) ent <= edge_mem[eidx[EW-1:0]];
    if (dl_we) dl_mem[in_ch.data.node_a[NW-1:0]] <= in_ch.data.deadline;
    dl_q <= dl_mem[to_i];
    dl_ok_q <= dl_valid[to_i];
    if (dist_we) dist_mem[dist_wa] <= dist_wd;
    dist_q <= dist_mem[dist_ra];
    dist_ok_q <= dist_ok[dist_ra];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
      node_count <= CountW'(64);
      edge_count <= '0;
      overflow <= 1'b0;
      out_ch.valid <= 1'b0;
      dl_valid <= '0;
      dist_ok <= '0;
      settled <= '0;
    end else begin
      if (cfg_we) node_count <= cfg_data;
      if (relax_hit) dist_ok[to_i] <= 1'b1;
      case (state)
        S_IDLE: begin
          if (in_ch.valid) begin
            case (cmd_t'(in_ch.data.command))
              CMD_CLEAR: begin
                edge_count <= '0;
                overflow <= 1'b0;
              end
              CMD_ADD_EDGE: begin
                if (edge_count < ECW'(MAX_EDGES)) edge_count <= edge_count + 1'b1;
                else overflow <= 1'b1;
              end
              CMD_DEADLINE: begin
                if (dl_we) dl_valid[in_ch.data.node_a[NW-1:0]] <= 1'b1;
              end
              default: begin
                if (node_count == '0) n_use <= CountW'(1);
                else if (node_count > CountW'(MAX_NODES)) n_use <= CountW'(MAX_NODES);
                else n_use <= node_count;
                state <= S_INIT;
              end
            endcase
          end
        end
        S_INIT: begin
          dist_ok <= MAX_NODES'(1);
          settled <= '0;
          round <= '0;
          idx <= '0;
          best <= n_use;
          best_d <= DistInf;
          state <= S_SREAD;
        end
        S_SREAD: begin
          state <= S_SCMP;
        end
        S_SCMP: begin
          if (!settled[idx_i] && dist_rd < best_d) begin
            best_d <= dist_rd;
            best <= idx;
          end
          idx <= idx + 1'b1;
          if (idx + 1'b1 == n_use) state <= S_PICK;
          else state <= S_SREAD;
        end
        S_PICK: begin
          if (best == n_use) begin
            idx <= '0;
            state <= S_EREQ;
          end else begin
            settled[best_i] <= 1'b1;
            eidx <= '0;
            state <= (edge_count == '0) ? S_WAIT : S_EREAD;
          end
        end
        S_EREAD: begin
          dir <= 1'b0;
          state <= S_DREAD;
        end
        S_DREAD: begin
          state <= S_RELAX;
        end
        S_RELAX: begin
          if (!dir) begin
            dir <= 1'b1;
            state <= S_DREAD;
          end else if (eidx + 1'b1 == edge_count) state <= S_WAIT;
          else begin
            eidx <= eidx + 1'b1;
            state <= S_EREAD;
          end
        end
        S_WAIT: begin
          idx <= '0;
          best <= n_use;
          best_d <= DistInf;
          if (round + 1'b1 == n_use) state <= S_EREQ;
          else begin
            round <= round + 1'b1;
            state <= S_SREAD;
          end
        end
        S_EREQ: begin
          state <= S_EMIT;
        end
        S_EMIT: begin
          if (!out_ch.valid || out_ch.ready) begin
            out_ch.valid <= 1'b1;
            out_ch.data.node_index <= idx[NodeW-1:0];
            out_ch.data.reachable <= dist_rd != DistInf;
            out_ch.data.reach_time <= (dist_rd != DistInf) ? dist_rd[TimeW-1:0] : '0;
            out_ch.data.edges_dropped <= overflow;
            out_ch.data.last <= (idx + 1'b1 == n_use);
            if (idx + 1'b1 == n_use) state <= S_IDLE;
            else state <= S_EREQ;
            idx <= idx + 1'b1;
          end
        end
        default: state <= S_IDLE;
      endcase
      if (out_ch.valid && out_ch.ready && !(state == S_EMIT))
        out_ch.valid <= 1'b0;
    end
  end
endmodule

/* design/spd_checker.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// spd_checker
// port level checks for the deadline shortest path block
// ----------------------------------------------------------------------------
module spd_checker (
  input logic clk,
  input logic rst,
  input logic in_ready,
  input logic out_valid,
  input logic out_ready,
  input logic out_last,
  input logic out_reachable,
  input logic [19:0] out_time
);
  a_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> out_valid) else $error("result dropped");
  a_unreach: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_reachable |-> out_time == '0) else $error("bad time");
  a_busy: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> !in_ready || out_last) else $error("ready during emit");
endmodule

bind shortest_path_with_node_deadlines spd_checker u_chk (
  .clk(clk), .rst(rst), .in_ready(in_ch.ready), .out_valid(out_ch.valid),
  .out_ready(out_ch.ready), .out_last(out_ch.data.last),
  .out_reachable(out_ch.data.reachable), .out_time(out_ch.data.reach_time)
);

/* dv/shortest_path_with_node_deadlines_test.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// shortest_path_with_node_deadlines_test
// self-checking bench for the deadline shortest path block
// ----------------------------------------------------------------------------
// A directed table covers node count extremes, deadline edges, self loops,
// zero weights and out-of-range endpoints. Random graph builds ending in a
// solve follow, together with an edge store overflow burst, under several
// valid/ready idle mixes and one long output stall. Each solve is predicted
// by a local array-scan Dijkstra and every result is compared in order.
// ----------------------------------------------------------------------------
module shortest_path_with_node_deadlines_test;
  import spd_pkg::*;

  localparam int ClkHalf = 6;
  localparam int WatchLimit = 1000000;
  localparam int HoldCycles = 600;
  localparam int Settle = 16;
  localparam int PhaseItems = 20;

  typedef struct {
    int        nodes;
    in_item_t  item;
    bit        typed;
    out_item_t result;
  } dir_row_t;

  logic clk;
  logic rst;
  logic cfg_we;
  logic [CountW-1:0] cfg_data;

  spd_in_if in_ch ();
  spd_out_if out_ch ();

  shortest_path_with_node_deadlines i_dut (
    .clk(clk),
    .rst(rst),
    .cfg_we(cfg_we),
    .cfg_data(cfg_data),
    .in_ch(in_ch),
    .out_ch(out_ch)
  );

  // graph mirror
  logic [NodeW-1:0]   edge_a [MaxEdgesDef];
  logic [NodeW-1:0]   edge_b [MaxEdgesDef];
  logic [WeightW-1:0] edge_w [MaxEdgesDef];
  int                 edge_total;
  logic [TimeW-1:0]   node_deadline [MaxNodesDef];
  bit                 drop_flag;
  int                 node_count;

  out_item_t pending_paths[$];
  dir_row_t  dir_rows[$];

  int s_pct;
  int r_pct;
  int hold_req;
  int hold_seen;
  int hold_cnt;
  int fail_count;
  int items_sent;
  int solves_sent;
  int results_seen;
  int idle_count;

  initial begin
    clk = 1'b0;
  end

  always #(ClkHalf) clk = ~clk;

  function automatic int nodes_in_use();
    if (node_count == 0) return 1;
    if (node_count > MaxNodesDef) return MaxNodesDef;
    return node_count;
  endfunction

  function automatic void predict_paths();
    logic [DistW-1:0] path_len [MaxNodesDef];
    bit               done [MaxNodesDef];
    logic [DistW-1:0] bd;
    logic [DistW-1:0] cand;
    int               n;
    int               best;
    int               from;
    int               to;
    out_item_t        res;
    n = nodes_in_use();
    for (int i = 0; i < MaxNodesDef; i++) begin
      path_len[i] = DistInf;
      done[i] = 1'b0;
    end
    path_len[0] = '0;
    for (int r = 0; r < n; r++) begin
      best = n;
      bd = DistInf;
      for (int i = 0; i < n; i++) begin
        if (!done[i] && path_len[i] < bd) begin
          bd = path_len[i];
          best = i;
        end
      end
      if (best >= n) break;
      done[best] = 1'b1;
      for (int e = 0; e < edge_total; e++) begin
        if (edge_a[e] >= n || edge_b[e] >= n) continue;
        for (int d = 0; d < 2; d++) begin
          from = (d == 0) ? edge_a[e] : edge_b[e];
          to = (d == 0) ? edge_b[e] : edge_a[e];
          if (from == best) begin
            cand = path_len[from] + DistW'(edge_w[e]);
            if (cand < path_len[to] && cand < {1'b0, node_deadline[to]})
              path_len[to] = cand;
          end
        end
      end
    end
    for (int i = 0; i < n; i++) begin
      res.node_index = NodeW'(i);
      res.reachable = (path_len[i] != DistInf);
      res.reach_time = res.reachable ? path_len[i][TimeW-1:0] : '0;
      res.edges_dropped = drop_flag;
      res.last = (i == n - 1);
      pending_paths.insert(pending_paths.size(), res);
    end
  endfunction

  function automatic void apply_item(in_item_t it);
    case (cmd_t'(it.command))
      CMD_CLEAR: begin
        edge_total = 0;
        drop_flag = 1'b0;
      end
      CMD_ADD_EDGE: begin
        if (edge_total < MaxEdgesDef) begin
          edge_a[edge_total] = it.node_a;
          edge_b[edge_total] = it.node_b;
          edge_w[edge_total] = it.edge_weight;
          edge_total++;
        end else begin
          drop_flag = 1'b1;
        end
      end
      CMD_DEADLINE: begin
        node_deadline[it.node_a] = it.deadline;
      end
      default: begin
        predict_paths();
        solves_sent++;
      end
    endcase
  endfunction

  function automatic in_item_t make_item(cmd_t cmd, int a, int b, int w, int dl);
    in_item_t it;
    it.command = cmd;
    it.node_a = NodeW'(a);
    it.node_b = NodeW'(b);
    it.edge_weight = WeightW'(w);
    it.deadline = TimeW'(dl);
    return it;
  endfunction

  task automatic push_item(in_item_t it);
    if (s_pct > 0 && $urandom_range(99) < s_pct) begin
      in_ch.valid <= 1'b0;
      repeat ($urandom_range(1, 3)) @(posedge clk);
    end
    in_ch.valid <= 1'b1;
    in_ch.data <= it;
    do @(posedge clk); while (!in_ch.ready);
    apply_item(it);
    items_sent++;
  endtask

  task automatic drain();
    in_ch.valid <= 1'b0;
    while (pending_paths.size() != 0) @(posedge clk);
    repeat (Settle) @(posedge clk);
  endtask

  task automatic set_nodes(int v);
    drain();
    cfg_we <= 1'b1;
    cfg_data <= CountW'(v);
    @(posedge clk);
    node_count = v;
    cfg_we <= 1'b0;
  endtask

  function automatic int pick_deadline();
    int roll;
    roll = $urandom_range(9);
    if (roll < 2) return $urandom_range(0, 300);
    if (roll == 2) return $urandom;
    return $urandom_range(200000, 20'hFFFFF);
  endfunction

  function automatic int pick_weight();
    int roll;
    roll = $urandom_range(19);
    if (roll == 0) return 0;
    if (roll < 4) return $urandom;
    return $urandom_range(1, 2000);
  endfunction

  task automatic run_graph();
    int n;
    int m;
    n = nodes_in_use();
    if (edge_total > 200 || $urandom_range(3) == 0)
      push_item(make_item(CMD_CLEAR, $urandom, $urandom, $urandom, $urandom));
    repeat ($urandom_range(0, n > 8 ? 8 : n)) begin
      if ($urandom_range(6) == 0)
        push_item(make_item(cmd_t'($urandom), $urandom, $urandom, $urandom, $urandom));
      else
        push_item(make_item(CMD_DEADLINE, $urandom_range(0, n - 1), $urandom,
                            $urandom, pick_deadline()));
    end
    m = $urandom_range(0, (n > 16) ? 24 : 3 * n);
    repeat (m) begin
      if ($urandom_range(6) == 0)
        push_item(make_item(cmd_t'($urandom), $urandom, $urandom, $urandom, $urandom));
      else if ($urandom_range(9) == 0)
        push_item(make_item(CMD_ADD_EDGE, $urandom, $urandom, pick_weight(), $urandom));
      else
        push_item(make_item(CMD_ADD_EDGE, $urandom_range(0, n - 1),
                            $urandom_range(0, n - 1), pick_weight(), $urandom));
    end
    push_item(make_item(CMD_SOLVE, $urandom, $urandom, $urandom, $urandom));
  endtask

  task automatic pick_nodes();
    int roll;
    roll = $urandom_range(19);
    if (roll == 0) set_nodes(0);
    else if (roll == 1) set_nodes(1);
    else if (roll == 2) set_nodes(MaxNodesDef);
    else if (roll == 3) set_nodes(127);
    else set_nodes($urandom_range(2, 12));
  endtask

  task automatic add_row(int nodes, in_item_t it, bit typed, out_item_t res);
    dir_row_t row;
    row.nodes = nodes;
    row.item = it;
    row.typed = typed;
    row.result = res;
    dir_rows.insert(dir_rows.size(), row);
  endtask

  // directed table
  task automatic run_table();
    out_item_t none;
    out_item_t src;
    none = '0;
    src = '{node_index: '0, reach_time: '0, reachable: 1'b1, edges_dropped: 1'b0,
            last: 1'b1};
    add_row(1, make_item(CMD_SOLVE, 0, 0, 0, 0), 1'b1, src);
    add_row(8, make_item(CMD_CLEAR, 63, 63, 16'hFFFF, 20'hFFFFF), 1'b0, none);
    add_row(-1, make_item(CMD_DEADLINE, 0, 0, 0, 0), 1'b0, none);
    add_row(-1, make_item(CMD_DEADLINE, 1, 0, 0, 100), 1'b0, none);
    add_row(-1, make_item(CMD_DEADLINE, 2, 63, 16'hFFFF, 20'hFFFFF), 1'b0, none);
    add_row(-1, make_item(CMD_DEADLINE, 3, 0, 0, 50), 1'b0, none);
    add_row(-1, make_item(CMD_DEADLINE, 4, 0, 0, 20'hFFFFF), 1'b0, none);
    add_row(-1, make_item(CMD_DEADLINE, 5, 0, 0, 20'hFFFFF), 1'b0, none);
    add_row(-1, make_item(CMD_ADD_EDGE, 0, 1, 99, 0), 1'b0, none);
    add_row(-1, make_item(CMD_ADD_EDGE, 1, 2, 16'hFFFF, 0), 1'b0, none);
    add_row(-1, make_item(CMD_ADD_EDGE, 3, 0, 50, 0), 1'b0, none);
    add_row(-1, make_item(CMD_ADD_EDGE, 2, 2, 0, 0), 1'b0, none);
    add_row(-1, make_item(CMD_ADD_EDGE, 2, 4, 0, 0), 1'b0, none);
    add_row(-1, make_item(CMD_ADD_EDGE, 63, 0, 1, 0), 1'b0, none);
    add_row(-1, make_item(CMD_ADD_EDGE, 5, 4, 1, 0), 1'b0, none);
    add_row(-1, make_item(CMD_ADD_EDGE, 63, 63, 16'hFFFF, 20'hFFFFF), 1'b0, none);
    add_row(-1, make_item(CMD_SOLVE, 0, 0, 0, 0), 1'b0, none);
    add_row(-1, make_item(CMD_DEADLINE, 1, 0, 0, 99), 1'b0, none);
    add_row(-1, make_item(CMD_SOLVE, 63, 63, 16'hFFFF, 20'hFFFFF), 1'b0, none);
    add_row(MaxNodesDef, make_item(CMD_SOLVE, 0, 0, 0, 0), 1'b0, none);
    add_row(-1, make_item(CMD_CLEAR, 0, 0, 0, 0), 1'b0, none);
    add_row(127, make_item(CMD_SOLVE, 0, 0, 0, 0), 1'b0, none);
    add_row(0, make_item(CMD_SOLVE, 0, 0, 0, 0), 1'b1, src);
    foreach (dir_rows[i]) begin
      if (dir_rows[i].nodes >= 0) set_nodes(dir_rows[i].nodes);
      push_item(dir_rows[i].item);
      if (dir_rows[i].typed) begin
        void'(pending_paths.pop_back());
        pending_paths.insert(pending_paths.size(), dir_rows[i].result);
      end
    end
  endtask

  // edge store overflow and recovery
  task automatic run_overflow();
    set_nodes(4);
    push_item(make_item(CMD_CLEAR, 0, 0, 0, 0));
    for (int i = 1; i < 4; i++)
      push_item(make_item(CMD_DEADLINE, i, 0, 0, 20'hFFFFF));
    repeat (MaxEdgesDef + 2)
      push_item(make_item(CMD_ADD_EDGE, $urandom_range(0, 5), $urandom_range(0, 3),
                          $urandom_range(1, 500), 0));
    push_item(make_item(CMD_SOLVE, 0, 0, 0, 0));
    push_item(make_item(CMD_CLEAR, 0, 0, 0, 0));
    push_item(make_item(CMD_SOLVE, 0, 0, 0, 0));
  endtask

  // result side
  always @(posedge clk) begin
    out_item_t want;
    out_item_t got;
    if (rst) begin
      out_ch.ready <= 1'b0;
      hold_cnt <= 0;
      hold_seen <= 0;
    end else begin
      if (hold_req != hold_seen) begin
        hold_seen <= hold_req;
        hold_cnt <= HoldCycles;
        out_ch.ready <= 1'b0;
      end else if (hold_cnt > 0) begin
        hold_cnt <= hold_cnt - 1;
        out_ch.ready <= 1'b0;
      end else begin
        out_ch.ready <= !(r_pct > 0 && $urandom_range(99) < r_pct);
      end
      if (out_ch.valid && out_ch.ready) begin
        got = out_ch.data;
        results_seen++;
        if (pending_paths.size() == 0) begin
          $error("result with nothing expected: %p", got);
          fail_count++;
        end else begin
          want = pending_paths.pop_front();
          if (got.node_index !== want.node_index) begin
            $error("node_index expected %0d got %0d", want.node_index, got.node_index);
            fail_count++;
          end
          if (got.reach_time !== want.reach_time) begin
            $error("reach_time expected %0d got %0d", want.reach_time, got.reach_time);
            fail_count++;
          end
          if (got.reachable !== want.reachable) begin
            $error("reachable expected %0d got %0d", want.reachable, got.reachable);
            fail_count++;
          end
          if (got.edges_dropped !== want.edges_dropped) begin
            $error("edges_dropped expected %0d got %0d", want.edges_dropped,
                   got.edges_dropped);
            fail_count++;
          end
          if (got.last !== want.last) begin
            $error("last expected %0d got %0d", want.last, got.last);
            fail_count++;
          end
        end
      end
    end
  end

  // watchdog
  always @(posedge clk) begin
    if (rst || (in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready)) begin
      idle_count <= 0;
    end else if (idle_count >= WatchLimit) begin
      $display("[shortest_path_with_node_deadlines] ERROR");
      $finish;
    end else begin
      idle_count <= idle_count + 1;
    end
  end

  initial begin
    int pct_s [4];
    int pct_r [4];
    int goal;
    pct_s = '{0, 57, 0, 35};
    pct_r = '{0, 0, 57, 35};
    rst = 1'b1;
    cfg_we = 1'b0;
    cfg_data = '0;
    in_ch.valid = 1'b0;
    in_ch.data = '0;
    s_pct = 0;
    r_pct = 0;
    hold_req = 0;
    fail_count = 0;
    items_sent = 0;
    solves_sent = 0;
    results_seen = 0;
    idle_count = 0;
    edge_total = 0;
    drop_flag = 1'b0;
    node_count = MaxNodesDef;
    foreach (node_deadline[i]) node_deadline[i] = '0;
    repeat (6) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    run_table();
    for (int p = 0; p < 4; p++) begin
      s_pct = pct_s[p];
      r_pct = pct_r[p];
      goal = items_sent + PhaseItems;
      if (p == 0) run_overflow();
      if (p == 2) begin
        set_nodes(8);
        hold_req <= hold_req + 1;
        repeat (2) run_graph();
        drain();
      end
      while (items_sent < goal) begin
        if ($urandom_range(3) == 0) pick_nodes();
        run_graph();
      end
    end
    drain();
    repeat (50) @(posedge clk);

    $display("covered %0d items, %0d solves, %0d results checked, %0d mismatches",
             items_sent, solves_sent, results_seen, fail_count);
    $display("node counts 0..127, idle mixes, long output stall and edge store overflow");
    if (fail_count == 0 && pending_paths.size() == 0) begin
      $display("[shortest_path_with_node_deadlines] OK");
    end else begin
      $display("[shortest_path_with_node_deadlines] ERROR");
    end
    $finish;
  end
endmodule

/* filelist.f */
design/spd_pkg.sv
design/spd_if.sv
design/shortest_path_with_node_deadlines.sv
design/spd_checker.sv
dv/shortest_path_with_node_deadlines_test.sv
